>>> src/priority_ready_queue_assert.svh
// Assertion macros shared by the checkers of this block.
// Both expect clk and rst in the scope where they are used.
`ifndef PRIORITY_READY_QUEUE_ASSERT_SVH
`define PRIORITY_READY_QUEUE_ASSERT_SVH

// same-cycle implication
`define PRQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/prq_pkg.sv
`timescale 1ns / 1ps
package prq_pkg;

  localparam int DEF_TASK_SLOTS    = 16;
  localparam int DEF_PRIORITY_BITS = 8;
  localparam int TASK_W            = 4;
  localparam int PRIO_IN_W         = 8;

  typedef enum logic [1:0] {
    ACT_REMOVE,
    ACT_BEFORE,
    ACT_AFTER,
    ACT_PRIO
  } action_t;

  // microprogram addresses
  typedef enum logic [3:0] {
    U_IDLE,
    U_LATCH,
    U_DISP,
    U_WALK,
    U_BEF0,
    U_BEF1,
    U_AFT0,
    U_AFT1,
    U_EMPTY,
    U_REM0,
    U_REM1,
    U_DONE
  } upc_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LATCH,
    DP_DECIDE,
    DP_WALK,
    DP_BEF0,
    DP_BEF1,
    DP_AFT0,
    DP_AFT1,
    DP_EMPTY,
    DP_REM0,
    DP_REM1,
    DP_DONE
  } dp_op_t;

  typedef enum logic [2:0] {
    BR_JMP,       // unconditional
    BR_ACCEPT,    // wait for an input beat
    BR_NOT_OK,    // jump when the request is out of range, else fall through
    BR_DISPATCH,  // multiway on action and queue state
    BR_WALK,      // stay while walking, leave on insert point
    BR_OUT        // wait for a free output register
  } br_t;

  typedef struct packed {
    dp_op_t op;
    br_t    br;
    upc_t   target;
  } ucode_t;

  typedef struct packed {
    logic    in_valid;
    logic    out_free;
    logic    ok;
    logic    queued;
    action_t act;
    logic    r_slot;
    logic    r_queued;
    logic    it_slot;
    logic    it_lower;
    logic    tail_slot;
  } flags_t;

  typedef struct packed {
    dp_op_t op;
    logic   go;
  } ctl_t;

  function automatic ucode_t ucode_rom(input upc_t pc);
    ucode_t cw;
    unique case (pc)
      U_IDLE:  cw = '{op: DP_IDLE,   br: BR_ACCEPT,   target: U_LATCH};
      U_LATCH: cw = '{op: DP_LATCH,  br: BR_NOT_OK,   target: U_DONE};
      U_DISP:  cw = '{op: DP_DECIDE, br: BR_DISPATCH, target: U_DONE};
      U_WALK:  cw = '{op: DP_WALK,   br: BR_WALK,     target: U_WALK};
      U_BEF0:  cw = '{op: DP_BEF0,   br: BR_JMP,      target: U_BEF1};
      U_BEF1:  cw = '{op: DP_BEF1,   br: BR_JMP,      target: U_DONE};
      U_AFT0:  cw = '{op: DP_AFT0,   br: BR_JMP,      target: U_AFT1};
      U_AFT1:  cw = '{op: DP_AFT1,   br: BR_JMP,      target: U_DONE};
      U_EMPTY: cw = '{op: DP_EMPTY,  br: BR_JMP,      target: U_DONE};
      U_REM0:  cw = '{op: DP_REM0,   br: BR_JMP,      target: U_REM1};
      U_REM1:  cw = '{op: DP_REM1,   br: BR_JMP,      target: U_DONE};
      U_DONE:  cw = '{op: DP_DONE,   br: BR_OUT,      target: U_IDLE};
      default: cw = '{op: DP_IDLE,   br: BR_JMP,      target: U_IDLE};
    endcase
    return cw;
  endfunction

endpackage

>>> src/prq_ram.sv
`timescale 1ns / 1ps
module prq_ram #(
  parameter int WIDTH = prq_pkg::DEF_PRIORITY_BITS,
  parameter int DEPTH = prq_pkg::DEF_TASK_SLOTS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/prq_seq.sv
`timescale 1ns / 1ps
module prq_seq (
  input  logic            clk,
  input  logic            rst,
  input  prq_pkg::flags_t fl,
  output prq_pkg::ctl_t   ctl,
  output logic            in_stall
);
  import prq_pkg::*;

  upc_t   upc;
  upc_t   upc_next;
  ucode_t cw;
  logic   go;

  assign cw = ucode_rom(upc);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    go       = ((cw.br == BR_ACCEPT) && fl.in_valid) || ((cw.br == BR_OUT) && fl.out_free);
    ctl.op   = cw.op;
    ctl.go   = go;
    in_stall = (upc != U_IDLE);
  end

  always_comb begin
    upc_next = upc;
    unique case (cw.br)
      BR_JMP: upc_next = cw.target;
      BR_ACCEPT, BR_OUT: begin
        if (go) upc_next = cw.target;
      end
      BR_NOT_OK: upc_next = fl.ok ? upc_t'(upc + 4'd1) : cw.target;
      BR_DISPATCH: begin
        priority if (fl.act == ACT_REMOVE) upc_next = fl.queued ? U_REM0 : U_DONE;
        else if (fl.queued)                upc_next = U_DONE;
        else if (fl.act == ACT_PRIO)       upc_next = U_WALK;
        else if (!fl.r_slot)               upc_next = U_EMPTY;
        else if (!fl.r_queued)             upc_next = U_DONE;
        else if (fl.act == ACT_BEFORE)     upc_next = U_BEF0;
        else                               upc_next = U_AFT0;
      end
      BR_WALK: begin
        priority if (!fl.it_slot) upc_next = fl.tail_slot ? U_AFT0 : U_EMPTY;
        else if (fl.it_lower)     upc_next = U_BEF0;
        else                      upc_next = U_WALK;
      end
      default: upc_next = U_IDLE;
    endcase
  end

endmodule

>>> src/prq_dp.sv
`timescale 1ns / 1ps
module prq_dp #(
  parameter int TASK_SLOTS    = prq_pkg::DEF_TASK_SLOTS,
  parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  prq_pkg::ctl_t                    ctl,
  output prq_pkg::flags_t                  fl,
  input  logic                             in_valid,
  input  logic [1:0]                       action,
  input  logic [prq_pkg::TASK_W-1:0]       task_req,
  input  logic [prq_pkg::TASK_W-1:0]       ref_task,
  input  logic                             ref_valid,
  input  logic [prq_pkg::PRIO_IN_W-1:0]    priority_req,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic [prq_pkg::TASK_W-1:0]       head_task,
  output logic                             head_valid,
  output logic [prq_pkg::TASK_W-1:0]       tail_task,
  output logic                             tail_valid,
  output logic                             mark_ready
);
  import prq_pkg::*;

  localparam int LW = $clog2(TASK_SLOTS + 1);
  localparam int IW = $clog2(TASK_SLOTS);
  localparam logic [LW-1:0] NIL = LW'(TASK_SLOTS);

  function automatic logic is_slot(input logic [LW-1:0] x);
    return x < NIL;
  endfunction

  // request registers
  action_t                act;
  logic                   ok;
  logic                   queued;
  logic                   ready;
  logic [IW-1:0]          t;
  logic [LW-1:0]          r;
  logic [LW-1:0]          it;
  logic [LW-1:0]          p;
  logic [LW-1:0]          n;
  logic [LW-1:0]          rp;
  logic [LW-1:0]          rn;
  logic [PRIORITY_BITS-1:0] prio;

  logic [LW-1:0] head;
  logic [LW-1:0] tail;

  // per-entry written marks; an unwritten link reads as null
  logic [TASK_SLOTS-1:0] nvalid;
  logic [TASK_SLOTS-1:0] pvalid;
  logic                  nv_q;
  logic                  pv_q;

  logic                     rd_en;
  logic [IW-1:0]            rd_a;
  logic                     nxt_we;
  logic [IW-1:0]            nxt_wa;
  logic [LW-1:0]            nxt_wd;
  logic                     prv_we;
  logic [IW-1:0]            prv_wa;
  logic [LW-1:0]            prv_wd;
  logic                     pri_we;
  logic [LW-1:0]            nxt_q;
  logic [LW-1:0]            prv_q;
  logic [PRIORITY_BITS-1:0] prio_d;
  logic [LW-1:0]            next_d;
  logic [LW-1:0]            prev_d;
  logic                     it_slot;
  logic                     it_lower;
  logic                     req_ok;
  logic [LW-1:0]            r_sel;

  assign next_d   = nv_q ? nxt_q : NIL;
  assign prev_d   = pv_q ? prv_q : NIL;
  assign it_slot  = is_slot(it);
  assign it_lower = prio_d < prio;

  assign req_ok = (32'(task_req) < TASK_SLOTS) &&
                  (!ref_valid || (action == ACT_REMOVE) || (action == ACT_PRIO) ||
                   (32'(ref_task) < TASK_SLOTS));

  always_comb begin
    priority if (ref_valid && ((action == ACT_BEFORE) || (action == ACT_AFTER))) begin
      r_sel = LW'(ref_task);
    end else if (action == ACT_AFTER) begin
      r_sel = tail;
    end else begin
      r_sel = head;
    end
  end

  always_comb begin
    fl.in_valid  = in_valid;
    fl.out_free  = !out_valid || !out_stall;
    fl.ok        = ok;
    fl.queued    = queued;
    fl.act       = act;
    fl.r_slot    = is_slot(r);
    fl.r_queued  = is_slot(prev_d) || is_slot(next_d) || (head == r);
    fl.it_slot   = it_slot;
    fl.it_lower  = it_lower;
    fl.tail_slot = is_slot(tail);
  end

  always_comb begin
    rd_en  = 1'b0;
    rd_a   = IW'(task_req);
    nxt_we = 1'b0;
    nxt_wa = t;
    nxt_wd = NIL;
    prv_we = 1'b0;
    prv_wa = t;
    prv_wd = NIL;
    pri_we = 1'b0;
    unique case (ctl.op)
      DP_IDLE: begin
        rd_en = ctl.go;
      end
      DP_LATCH: begin
        rd_en = 1'b1;
        rd_a  = IW'(r);
      end
      DP_DECIDE: begin
        pri_we = (act == ACT_PRIO) && !queued;
      end
      DP_WALK: begin
        // follow the next link straight off the read port
        rd_en = it_slot && !it_lower;
        rd_a  = IW'(next_d);
      end
      DP_BEF0: begin
        nxt_we = 1'b1;
        nxt_wd = r;
        prv_we = 1'b1;
        prv_wd = rp;
      end
      DP_BEF1: begin
        nxt_we = is_slot(rp);
        nxt_wa = IW'(rp);
        nxt_wd = LW'(t);
        prv_we = 1'b1;
        prv_wa = IW'(r);
        prv_wd = LW'(t);
      end
      DP_AFT0: begin
        prv_we = 1'b1;
        prv_wd = r;
        nxt_we = 1'b1;
        nxt_wd = rn;
      end
      DP_AFT1: begin
        nxt_we = 1'b1;
        nxt_wa = IW'(r);
        nxt_wd = LW'(t);
        prv_we = is_slot(rn);
        prv_wa = IW'(rn);
        prv_wd = LW'(t);
      end
      DP_EMPTY, DP_REM1: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      DP_REM0: begin
        nxt_we = is_slot(p);
        nxt_wa = IW'(p);
        nxt_wd = n;
        prv_we = is_slot(n);
        prv_wa = IW'(n);
        prv_wd = p;
      end
      DP_DONE: begin
      end
      default: begin
      end
    endcase
  end

  prq_ram #(.WIDTH(LW), .DEPTH(TASK_SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_wa),
    .wdata (nxt_wd),
    .re    (rd_en),
    .raddr (rd_a),
    .rdata (nxt_q)
  );

  prq_ram #(.WIDTH(LW), .DEPTH(TASK_SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_wa),
    .wdata (prv_wd),
    .re    (rd_en),
    .raddr (rd_a),
    .rdata (prv_q)
  );

  prq_ram #(.WIDTH(PRIORITY_BITS), .DEPTH(TASK_SLOTS)) u_prio_ram (
    .clk   (clk),
    .we    (pri_we),
    .waddr (t),
    .wdata (prio),
    .re    (rd_en),
    .raddr (rd_a),
    .rdata (prio_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL;
      tail      <= NIL;
      nvalid    <= '0;
      pvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (nxt_we) nvalid[nxt_wa] <= 1'b1;
      if (prv_we) pvalid[prv_wa] <= 1'b1;
      unique case (ctl.op)
        DP_BEF1: begin
          if (!is_slot(rp)) head <= LW'(t);
        end
        DP_AFT1: begin
          if (!is_slot(rn)) tail <= LW'(t);
        end
        DP_EMPTY: begin
          head <= LW'(t);
          tail <= LW'(t);
        end
        DP_REM0: begin
          if (!is_slot(p)) head <= n;
          if (!is_slot(n)) tail <= p;
        end
        default: begin
        end
      endcase
      if ((ctl.op == DP_DONE) && ctl.go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      nv_q <= nvalid[rd_a];
      pv_q <= pvalid[rd_a];
    end
    unique case (ctl.op)
      DP_IDLE: begin
        if (ctl.go) begin
          act   <= action_t'(action);
          ok    <= req_ok;
          t     <= IW'(task_req);
          r     <= r_sel;
          it    <= head;
          prio  <= PRIORITY_BITS'(priority_req);
          ready <= 1'b0;
        end
      end
      DP_LATCH: begin
        p      <= prev_d;
        n      <= next_d;
        queued <= is_slot(prev_d) || is_slot(next_d) || (head == LW'(t));
      end
      DP_DECIDE: begin
        rp <= prev_d;
        rn <= next_d;
        if ((act == ACT_PRIO) && !queued) ready <= 1'b1;
      end
      DP_WALK: begin
        if (!it_slot) begin
          // ran off the end: append behind the tail
          r  <= tail;
          rn <= NIL;
        end else if (it_lower) begin
          r  <= it;
          rp <= prev_d;
        end else begin
          it <= next_d;
        end
      end
      DP_DONE: begin
        if (ctl.go) begin
          head_task  <= is_slot(head) ? TASK_W'(head) : '0;
          head_valid <= is_slot(head);
          tail_task  <= is_slot(tail) ? TASK_W'(tail) : '0;
          tail_valid <= is_slot(tail);
          mark_ready <= ready;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/priority_ready_queue.sv
`timescale 1ns / 1ps
// Doubly linked ready queue over TASK_SLOTS task slots, kept in priority order.
// Input channel (in_valid / in_stall): one beat carries action, task_req,
// ref_task, ref_valid and priority_req. Output channel (out_valid / out_stall):
// one beat per input beat with head and tail after the action, and mark_ready
// set when a priority insert linked the task.
// Items are handled one at a time by a small microprogram. It latches the
// request, ends on an out-of-range request, dispatches on action and queue
// state, then writes the links for a remove or an insert before or after, also
// into an empty queue; an ignored action goes straight to the result. A
// priority insert first walks from the head to the first task with a lower
// priority value, or to the end. The next beat is taken once the result is in
// the output register. The walk follows one next link per cycle through the
// registered read port of the link memories; it sets the worst case.
// A finished result waits in the output register while out_stall is high; the
// next input beat is still taken meanwhile, and its result waits in turn.
// Reset (rst, synchronous) empties the queue at once: every link reads as null
// through per-slot written marks. Priorities of never inserted slots are
// undefined.
module priority_ready_queue #(
  parameter int TASK_SLOTS    = prq_pkg::DEF_TASK_SLOTS,
  parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    action,
  input  logic [prq_pkg::TASK_W-1:0]    task_req,
  input  logic [prq_pkg::TASK_W-1:0]    ref_task,
  input  logic                          ref_valid,
  input  logic [prq_pkg::PRIO_IN_W-1:0] priority_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [prq_pkg::TASK_W-1:0]    head_task,
  output logic                          head_valid,
  output logic [prq_pkg::TASK_W-1:0]    tail_task,
  output logic                          tail_valid,
  output logic                          mark_ready
);
  import prq_pkg::*;

  flags_t fl;
  ctl_t   ctl;

  prq_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .fl       (fl),
    .ctl      (ctl),
    .in_stall (in_stall)
  );

  prq_dp #(
    .TASK_SLOTS    (TASK_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .fl           (fl),
    .in_valid     (in_valid),
    .action       (action),
    .task_req     (task_req),
    .ref_task     (ref_task),
    .ref_valid    (ref_valid),
    .priority_req (priority_req),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .head_task    (head_task),
    .head_valid   (head_valid),
    .tail_task    (tail_task),
    .tail_valid   (tail_valid),
    .mark_ready   (mark_ready)
  );

endmodule

>>> src/prq_check.sv
`timescale 1ns / 1ps
`include "priority_ready_queue_assert.svh"
module prq_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    action,
  input logic [prq_pkg::TASK_W-1:0]    task_req,
  input logic [prq_pkg::TASK_W-1:0]    ref_task,
  input logic                          ref_valid,
  input logic [prq_pkg::PRIO_IN_W-1:0] priority_req,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [prq_pkg::TASK_W-1:0]    head_task,
  input logic                          head_valid,
  input logic [prq_pkg::TASK_W-1:0]    tail_task,
  input logic                          tail_valid,
  input logic                          mark_ready
);
  import prq_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend;  // beats taken in, results not yet taken out

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else begin
      pend <= pend + 2'(in_acc) - 2'(out_acc);
    end
  end

  `PRQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(head_task) && $stable(tail_task) && $stable(head_valid) && $stable(tail_valid) && $stable(mark_ready), "stalled result changed")

  `PRQ_ASSERT_IMP(a_no_orphan, out_valid, pend != 2'd0, "result without an input beat")

  `PRQ_ASSERT_IMP(a_one_ahead, pend == 2'd2, in_stall, "input taken with two results pending")

  `PRQ_ASSERT_IMP(a_empty, out_valid && !head_valid, !tail_valid && (head_task == {TASK_W{1'b0}}) && (tail_task == {TASK_W{1'b0}}), "empty queue reports a slot")

endmodule

bind priority_ready_queue prq_check u_prq_check (.*);
